FILE: rtl/shash_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared types, round constants and the initial chaining value.
// ----------------------------------------------------------------------------
package shash_pkg;

  typedef logic [31:0] shash_word_t;
  typedef logic [0:7][31:0] shash_state_t;
  typedef logic [511:0] shash_block_t;

  // One queued input item after classification.
  typedef struct packed {
    logic       finish;
    logic [7:0] data;
  } shash_item_t;

  // Requests from the byte sequencer to the round unit.
  typedef struct packed {
    logic start;
    logic reinit;
  } shash_cmp_req_t;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] LEN_FILL   = 6'd55;
  localparam logic [2:0] IDX_LAST   = 3'd7;
  localparam logic [5:0] ROUND_LAST = 6'd63;

  localparam shash_state_t HASH_INIT = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [0:63][31:0] ROUND_K = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic shash_word_t rotr(input shash_word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic shash_word_t big_sigma0(input shash_word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic shash_word_t big_sigma1(input shash_word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic shash_word_t small_sigma0(input shash_word_t x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic shash_word_t small_sigma1(input shash_word_t x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

FILE: rtl/shash_if.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher channel interfaces
// Valid/ready channels for message items and digest words.
// ----------------------------------------------------------------------------
interface shash_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface shash_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface

FILE: rtl/shash_front.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher front end
// Accepts input transactions, tags them as data or finish, and queues them.
// ----------------------------------------------------------------------------
module shash_front #(
  parameter int Depth = shash_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  shash_in_if.sink              in_chan,
  output logic                  q_valid,
  output shash_pkg::shash_item_t q_item,
  input  logic                  q_pop
);
  import shash_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  shash_item_t         queue_r [Depth];
  logic [PtrW-1:0]     head_r, head_nxt;
  logic [PtrW-1:0]     tail_r, tail_nxt;
  logic [CntW-1:0]     count_r, count_nxt;
  logic                push;
  shash_item_t         item_in;

  assign in_chan.ready = (count_r != CntW'(Depth));
  assign push          = in_chan.valid && in_chan.ready;
  assign q_valid       = (count_r != '0);
  assign q_item        = queue_r[head_r];

  always_comb begin
    item_in.finish = in_chan.op;
    item_in.data   = in_chan.op ? 8'h00 : in_chan.data_byte;
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (push) begin
      tail_nxt = (tail_r == PtrW'(Depth - 1)) ? '0 : tail_r + 1'b1;
    end
    if (q_pop) begin
      head_nxt = (head_r == PtrW'(Depth - 1)) ? '0 : head_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[tail_r] <= item_in;
    end
  end

endmodule

FILE: rtl/shash_compress.sv
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Holds the chaining state and runs one compression round per cycle.
// ----------------------------------------------------------------------------
module shash_compress (
  input  logic                     clk,
  input  logic                     rst_n,
  input  shash_pkg::shash_cmp_req_t cmp_req,
  input  shash_pkg::shash_block_t  block_in,
  output logic                     busy,
  output shash_pkg::shash_state_t  chain
);
  import shash_pkg::*;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_ROUND,
    CS_FOLD
  } cstate_t;

  cstate_t              state_r;
  shash_state_t         chain_r;
  shash_state_t         work_r, work_nxt;
  logic [0:15][31:0]    sched_r, sched_nxt;
  logic [5:0]           round_r;
  shash_word_t          t1, t2, w_new;

  assign busy  = (state_r != CS_IDLE);
  assign chain = chain_r;

  always_comb begin
    t1 = work_r[7] + big_sigma1(work_r[4])
         + ((work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]))
         + ROUND_K[round_r] + sched_r[0];
    t2 = big_sigma0(work_r[0])
         + ((work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]));
    w_new = small_sigma1(sched_r[14]) + sched_r[9] + small_sigma0(sched_r[1]) + sched_r[0];

    work_nxt[0] = t1 + t2;
    work_nxt[1] = work_r[0];
    work_nxt[2] = work_r[1];
    work_nxt[3] = work_r[2];
    work_nxt[4] = work_r[3] + t1;
    work_nxt[5] = work_r[4];
    work_nxt[6] = work_r[5];
    work_nxt[7] = work_r[6];

    // The schedule window slides by one word per round.
    for (int j = 0; j < 15; j++) begin
      sched_nxt[j] = sched_r[j+1];
    end
    sched_nxt[15] = w_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      chain_r <= HASH_INIT;
      round_r <= '0;
    end else begin
      case (state_r)
        CS_IDLE: begin
          if (cmp_req.start) begin
            state_r <= CS_ROUND;
            round_r <= '0;
            work_r  <= chain_r;
            for (int j = 0; j < 16; j++) begin
              sched_r[j] <= block_in[511 - 32*j -: 32];
            end
          end else if (cmp_req.reinit) begin
            chain_r <= HASH_INIT;
          end
        end
        CS_ROUND: begin
          work_r  <= work_nxt;
          sched_r <= sched_nxt;
          round_r <= round_r + 1'b1;
          if (round_r == ROUND_LAST) begin
            state_r <= CS_FOLD;
          end
        end
        CS_FOLD: begin
          for (int j = 0; j < 8; j++) begin
            chain_r[j] <= chain_r[j] + work_r[j];
          end
          state_r <= CS_IDLE;
        end
        default: begin
          state_r <= CS_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/shash_back.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher back end
// Fills the block buffer, pads finished messages and emits the digest words.
// ----------------------------------------------------------------------------
module shash_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  shash_pkg::shash_item_t    q_item,
  output logic                      q_pop,
  output shash_pkg::shash_cmp_req_t cmp_req,
  output shash_pkg::shash_block_t   cmp_block,
  input  logic                      cmp_busy,
  input  shash_pkg::shash_state_t   chain,
  shash_out_if.source               out_chan
);
  import shash_pkg::*;

  typedef enum logic [2:0] {
    ST_ABSORB,
    ST_PAD80,
    ST_ZERO,
    ST_LEN,
    ST_DRAIN,
    ST_EMIT
  } bstate_t;

  bstate_t      state_r, state_nxt;
  shash_block_t blk_r, blk_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [63:0]  msg_r, msg_nxt;
  logic [63:0]  len_r, len_nxt;
  logic [2:0]   len_cnt_r, len_cnt_nxt;
  logic [2:0]   idx_r, idx_nxt;
  logic         out_valid_r, out_valid_nxt;
  shash_word_t  out_word_r, out_word_nxt;
  logic [2:0]   out_index_r, out_index_nxt;
  logic         out_last_r, out_last_nxt;
  logic         push_req, push_stall, push_ok;
  logic [7:0]   push_data;

  // The buffer cannot take its last byte while the round unit is still busy.
  assign push_stall = (fill_r == FILL_LAST) && cmp_busy;
  assign push_ok    = push_req && !push_stall;
  assign cmp_block  = {blk_r[503:0], push_data};

  assign out_chan.valid       = out_valid_r;
  assign out_chan.digest_word = out_word_r;
  assign out_chan.word_index  = out_index_r;
  assign out_chan.last_word   = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    blk_nxt        = blk_r;
    fill_nxt       = fill_r;
    msg_nxt        = msg_r;
    len_nxt        = len_r;
    len_cnt_nxt    = len_cnt_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_word_nxt   = out_word_r;
    out_index_nxt  = out_index_r;
    out_last_nxt   = out_last_r;
    push_req       = 1'b0;
    push_data      = 8'h00;
    q_pop          = 1'b0;
    cmp_req.start  = 1'b0;
    cmp_req.reinit = 1'b0;

    case (state_r)
      ST_ABSORB: begin
        if (q_valid) begin
          if (q_item.finish) begin
            q_pop     = 1'b1;
            len_nxt   = {msg_r[60:0], 3'b000};
            msg_nxt   = '0;
            state_nxt = ST_PAD80;
          end else begin
            push_req  = 1'b1;
            push_data = q_item.data;
            if (!push_stall) begin
              q_pop   = 1'b1;
              msg_nxt = msg_r + 64'd1;
            end
          end
        end
      end
      ST_PAD80: begin
        push_req  = 1'b1;
        push_data = PAD_BYTE;
        if (!push_stall) begin
          state_nxt = (fill_r == LEN_FILL) ? ST_LEN : ST_ZERO;
        end
      end
      ST_ZERO: begin
        push_req = 1'b1;
        if (!push_stall && fill_r == LEN_FILL) begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        push_req  = 1'b1;
        push_data = len_r[63:56];
        if (!push_stall) begin
          len_nxt     = {len_r[55:0], 8'h00};
          len_cnt_nxt = len_cnt_r + 1'b1;
          if (len_cnt_r == IDX_LAST) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!cmp_busy) begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = chain[idx_r];
          out_index_nxt = idx_r;
          out_last_nxt  = (idx_r == IDX_LAST);
          idx_nxt       = idx_r + 1'b1;
          if (idx_r == IDX_LAST) begin
            cmp_req.reinit = 1'b1;
            state_nxt      = ST_ABSORB;
          end
        end
      end
      default: begin
        state_nxt = ST_ABSORB;
      end
    endcase

    if (push_ok) begin
      blk_nxt  = cmp_block;
      fill_nxt = fill_r + 1'b1;
      if (fill_r == FILL_LAST) begin
        cmp_req.start = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ABSORB;
      fill_r      <= '0;
      msg_r       <= '0;
      len_cnt_r   <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      msg_r       <= msg_nxt;
      len_cnt_r   <= len_cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    blk_r       <= blk_nxt;
    len_r       <= len_nxt;
    out_word_r  <= out_word_nxt;
    out_index_r <= out_index_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

FILE: rtl/sha256_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and returns the eight digest words on each finish.
//
//   Channel   Direction  Payload                              Transaction
//   in_chan   input      op, data_byte                        valid && ready
//   out_chan  output     digest_word, word_index, last_word   valid && ready
//
// Data bytes are absorbed at one per cycle; a full block starts the round unit,
// which loads it, runs 64 rounds and folds into the chaining state. A finish
// pads at one byte per cycle, waits for the last compression and hands out
// eight words, one per cycle while the sink is ready. A block's last byte waits
// for a busy round unit. Reset loads the initial hash values and empties the
// input queue, which keeps accepting while the back end pads or emits.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top #(
  parameter int QueueDepth = shash_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  shash_in_if.sink    in_chan,
  shash_out_if.source out_chan
);
  import shash_pkg::*;

  logic           q_valid;
  logic           q_pop;
  shash_item_t    q_item;
  shash_cmp_req_t cmp_req;
  shash_block_t   cmp_block;
  logic           cmp_busy;
  shash_state_t   chain;

  shash_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_chan(in_chan),
    .q_valid(q_valid),
    .q_item (q_item),
    .q_pop  (q_pop)
  );

  shash_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .cmp_req  (cmp_req),
    .cmp_block(cmp_block),
    .cmp_busy (cmp_busy),
    .chain    (chain),
    .out_chan (out_chan)
  );

  shash_compress u_compress (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmp_req (cmp_req),
    .block_in(cmp_block),
    .busy    (cmp_busy),
    .chain   (chain)
  );

  // A block is never handed to the round unit while it is still working.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_req.start |-> !cmp_busy)
    else $error("compression started while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_req.start |=> cmp_busy)
    else $error("round unit did not pick up a block");

  a_reinit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_req.reinit |-> (!cmp_busy && !cmp_req.start))
    else $error("chaining state reloaded during a compression");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from an empty input queue");

endmodule
